// ===== rtl/page_frame_free_list_allocator_top_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// cond must never hold outside reset
`define PFA_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

// ante in one cycle implies cons in the next
`define PFA_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfa_pkg.sv =====
// Package: widths, codes and helpers of the page frame allocator.
package pfa_pkg;

    localparam int CMD_W      = 2;
    localparam int FRAME_IN_W = 40;
    localparam int COUNT_W    = 13;
    localparam int MTYPE_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 40;

    localparam int DEPTH_DEF      = 4096;
    localparam int FRAME_BITS_DEF = 40;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

    // UEFI memory types that count as usable
    localparam logic [MTYPE_W-1:0] MT_LOADER_CODE  = 4'd1;
    localparam logic [MTYPE_W-1:0] MT_LOADER_DATA  = 4'd2;
    localparam logic [MTYPE_W-1:0] MT_BS_CODE      = 4'd3;
    localparam logic [MTYPE_W-1:0] MT_BS_DATA      = 4'd4;
    localparam logic [MTYPE_W-1:0] MT_CONVENTIONAL = 4'd7;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    function automatic logic is_usable(input logic [MTYPE_W-1:0] mtype);
        logic res;
        case (mtype) inside
            MT_LOADER_CODE, MT_LOADER_DATA, MT_BS_CODE, MT_BS_DATA,
            MT_CONVENTIONAL: res = 1'b1;
            default:         res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/pfa_if.sv =====
// Interfaces: request and response channels of the allocator.
interface pfa_req_if import pfa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [FRAME_IN_W-1:0] page_frame;
    logic [COUNT_W-1:0]    page_count;
    logic [MTYPE_W-1:0]    memory_type;

    modport source (output valid, command, page_frame, page_count, memory_type,
                    input ready);
    modport sink   (input valid, command, page_frame, page_count, memory_type,
                    output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FRAME_IN_W-1:0] alloc_frame;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    free_pages;
    logic [TOTAL_W-1:0]    total_pages;
    logic [TOTAL_W-1:0]    reserved_pages;

    modport source (output valid, alloc_frame, status, free_pages, total_pages,
                    reserved_pages, input ready);
    modport sink   (input valid, alloc_frame, status, free_pages, total_pages,
                    reserved_pages, output ready);
endinterface

// ===== rtl/page_frame_free_list_allocator_top.sv =====
// Top level: FIFO free list page frame allocator with request/response words.
// Channels: i_req (sink) takes one request word (command, page_frame,
//   page_count, memory_type); o_rsp (source) returns exactly one response word
//   per request (alloc_frame, status, free_pages, total_pages, reserved_pages).
//   A word moves on a clock edge with valid and ready high.
// Timing: one request is worked at a time; i_req.ready is high only while idle.
//   Allocate reads the head of the frame store (registered RAM read) and goes
//   through S_ALLOC to S_FINISH. A free, or a load of a usable type, pushes one
//   frame per cycle through a single incrementer and RAM write port in S_PUSH
//   (a frame that meets a full store is dropped), then goes to S_FINISH.
//   Everything else (empty list, unusable load, unknown command) goes straight
//   to S_FINISH.
// Stall: the response sits in an output register; a request can be accepted
//   while it waits. A finished request holds in the finish state until that
//   register frees up.
// Reset: i_rst_n (synchronous, active low) empties the list and clears the
//   loaded total. The frame store is not cleared; only written entries are
//   ever read back.
`include "page_frame_free_list_allocator_top_macros.svh"

module page_frame_free_list_allocator_top import pfa_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfa_req_if.sink   i_req,
    pfa_rsp_if.source o_rsp
);

    localparam int OW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PUSH   = 4'b0010,
        S_ALLOC  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [FRAME_BITS-1:0] r_frame, n_frame;      // next frame of the run
    logic [COUNT_W-1:0]    r_left, n_left;        // frames still to push
    logic                  r_drop, n_drop;        // some push hit a full store
    logic [FRAME_IN_W-1:0] r_given, n_given;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [TOTAL_W-1:0]    r_total, n_total;

    logic                  r_out_valid, n_out_valid;
    logic [FRAME_IN_W-1:0] r_out_frame;
    logic [STATUS_W-1:0]   r_out_status;
    logic [COUNT_W-1:0]    r_out_free;
    logic [TOTAL_W-1:0]    r_out_total;
    logic [TOTAL_W-1:0]    r_out_resv;

    t_ring_ctl             ring_ctl;
    logic [FRAME_BITS-1:0] ring_rd_frame;
    logic [OW-1:0]         ring_occ;
    logic                  ring_full;
    logic                  ring_empty;

    logic                  req_fire;
    logic                  out_load;
    logic [TOTAL_W:0]      total_sum;
    logic [TOTAL_W:0]      resv_diff;
    logic [FRAME_BITS+FRAME_IN_W-1:0] frame_in_ext;
    logic [FRAME_BITS+FRAME_IN_W-1:0] frame_out_ext;
    logic [OW+COUNT_W-1:0]            occ_ext;

    pfa_frame_ring #(
        .DEPTH      (DEPTH),
        .FRAME_BITS (FRAME_BITS)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ring_ctl),
        .i_wr_frame (r_frame),
        .o_rd_frame (ring_rd_frame),
        .o_occ      (ring_occ),
        .o_full     (ring_full),
        .o_empty    (ring_empty)
    );

    assign req_fire = i_req.valid && i_req.ready;
    assign out_load = (r_state == S_FINISH) && (!r_out_valid || o_rsp.ready);

    // width adaption between the 40-bit ports and FRAME_BITS-wide entries
    assign frame_in_ext  = {{FRAME_BITS{1'b0}}, i_req.page_frame};
    assign frame_out_ext = {{FRAME_IN_W{1'b0}}, ring_rd_frame};
    assign occ_ext       = {{COUNT_W{1'b0}}, ring_occ};

    // saturating load total, one 41-bit add
    assign total_sum = {1'b0, r_total} + (TOTAL_W + 1)'(i_req.page_count);
    // reserved = total - free, floored at zero
    assign resv_diff = {1'b0, r_total} - (TOTAL_W + 1)'(ring_occ);

    always_comb begin
        n_state     = r_state;
        n_frame     = r_frame;
        n_left      = r_left;
        n_drop      = r_drop;
        n_given     = r_given;
        n_status    = r_status;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        ring_ctl    = '0;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_frame  = frame_in_ext[FRAME_BITS-1:0];
                    n_left   = i_req.page_count;
                    n_drop   = 1'b0;
                    n_given  = '0;
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                    case (i_req.command)
                        CMD_ALLOC: begin
                            if (ring_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        CMD_FREE: begin
                            n_state = S_PUSH;
                        end
                        CMD_LOAD: begin
                            n_total = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                            if (is_usable(i_req.memory_type)) begin
                                n_state = S_PUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PUSH: begin
                if (r_left == '0) begin
                    n_status = r_drop ? ST_DROP : ST_OK;
                    n_state  = S_FINISH;
                end else begin
                    if (ring_full) begin
                        n_drop = 1'b1;
                    end else begin
                        ring_ctl.push = 1'b1;
                    end
                    n_frame = r_frame + 1'b1;   // wraps modulo 2^FRAME_BITS
                    n_left  = r_left - 1'b1;
                end
            end
            S_ALLOC: begin
                // head entry was read out on the accept edge
                n_given      = frame_out_ext[FRAME_IN_W-1:0];
                ring_ctl.pop = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame  <= n_frame;
        r_left   <= n_left;
        r_drop   <= n_drop;
        r_given  <= n_given;
        r_status <= n_status;
        if (out_load) begin
            r_out_frame  <= r_given;
            r_out_status <= r_status;
            r_out_free   <= occ_ext[COUNT_W-1:0];
            r_out_total  <= r_total;
            r_out_resv   <= resv_diff[TOTAL_W] ? '0 : resv_diff[TOTAL_W-1:0];
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.alloc_frame    = r_out_frame;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.free_pages     = r_out_free;
    assign o_rsp.total_pages    = r_out_total;
    assign o_rsp.reserved_pages = r_out_resv;

    `PFA_NEVER(a_ready_busy, i_clk, i_rst_n, i_req.ready && (r_left != '0) && (r_state == S_PUSH), "ready while pushing")
    `PFA_NEXT(a_alloc_pop, i_clk, i_rst_n, r_state == S_ALLOC, r_state == S_FINISH, "allocate did not finish")
    `PFA_NEXT(a_load_fire, i_clk, i_rst_n, out_load, r_out_valid && (r_state == S_IDLE), "response not loaded")

endmodule

// ===== rtl/pfa_frame_ring.sv =====
// Circular free frame store with head, tail and occupancy tracking.
`include "page_frame_free_list_allocator_top_macros.svh"

module pfa_frame_ring import pfa_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF,
    localparam int IW = $clog2(DEPTH),
    localparam int OW = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ring_ctl             i_ctl,
    input  logic [FRAME_BITS-1:0] i_wr_frame,
    output logic [FRAME_BITS-1:0] o_rd_frame,
    output logic [OW-1:0]         o_occ,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_CNT = OW'(DEPTH);

    logic [FRAME_BITS-1:0] r_mem [DEPTH];
    logic [FRAME_BITS-1:0] r_rd_frame;
    logic [IW-1:0]         r_head, n_head;
    logic [IW-1:0]         r_tail, n_tail;
    logic [OW-1:0]         r_occ, n_occ;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (i_ctl.push) begin
            n_tail = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
        end
        if (i_ctl.pop) begin
            n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.push && !i_ctl.pop) begin
            n_occ = r_occ + 1'b1;
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_occ = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    // storage: one write port at the tail, registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_wr_frame;
        end
        r_rd_frame <= r_mem[r_head];
    end

    assign o_rd_frame = r_rd_frame;
    assign o_occ      = r_occ;
    assign o_full     = (r_occ == FULL_CNT);
    assign o_empty    = (r_occ == '0);

    `PFA_NEVER(a_push_full, i_clk, i_rst_n, i_ctl.push && o_full, "push into full ring")
    `PFA_NEVER(a_pop_empty, i_clk, i_rst_n, i_ctl.pop && o_empty, "pop from empty ring")
    `PFA_NEVER(a_occ_range, i_clk, i_rst_n, r_occ > FULL_CNT, "occupancy above depth")
    `PFA_NEXT(a_push_count, i_clk, i_rst_n, i_ctl.push && !i_ctl.pop, r_occ == $past(r_occ) + 1'b1, "push did not count")

endmodule
